// File: src/assert_macros.svh
// Assertion macros shared by the tile renderer sources.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/snes_ttr_pkg.sv
// Types and constants of the SNES tilemap tile renderer.
// No dependencies; the interfaces, the remainder unit, the top level and the testbench import it.
package snes_ttr_pkg;

   // Opcodes of an input beat.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // A tilemap word with every bit set marks an empty slot.
   localparam logic [15:0] EMPTY_MAP_WORD = 16'hFFFF;

   // Tile geometry: 8x8 pixels, sheet rows 128 bytes apart.
   localparam int unsigned TILE_W          = 8;
   localparam int unsigned SHEET_ROW_PITCH = 128;
   localparam int unsigned ROW_SKIP        = SHEET_ROW_PITCH - (TILE_W - 1);
   localparam logic [5:0]  LAST_PIXEL      = 6'd63;

   // Width of an operand of the remainder unit.
   localparam int unsigned OPERAND_W = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_MOD,
      ST_SLOT_MOD,
      ST_BASE_MOD,
      ST_DRAW
   } state_type;

   typedef enum logic {
      DIV_SEL_SHEET,
      DIV_SEL_SCREEN
   } div_sel_type;

   typedef struct packed {
      logic                 start;
      div_sel_type          sel;
      logic [OPERAND_W-1:0] operand;
   } mod_req_type;

   typedef struct packed {
      logic                 done;
      logic [OPERAND_W-1:0] value;
   } mod_rsp_type;

endpackage

// File: src/snes_ttr_req_if.sv
// Input channel of the tile renderer: valid/ready plus the item fields.
// Depends on snes_ttr_pkg.
interface snes_ttr_req_if import snes_ttr_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        op;
   logic [15:0] sheet_addr;
   logic [7:0]  sheet_byte;
   logic [9:0]  tile_slot;
   logic [OPERAND_W-1:0] map_word;

   modport source (
      output valid, op, sheet_addr, sheet_byte, tile_slot, map_word,
      input  ready
   );

   modport sink (
      input  valid, op, sheet_addr, sheet_byte, tile_slot, map_word,
      output ready
   );
endinterface

// File: src/snes_ttr_rsp_if.sv
// Result channel of the tile renderer: valid/ready plus one pixel.
// Depends on snes_ttr_pkg.
interface snes_ttr_rsp_if import snes_ttr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OPERAND_W-1:0] pixel_addr;
   logic [7:0]           pixel_value;
   logic                 last;

   modport source (
      output valid, pixel_addr, pixel_value, last,
      input  ready
   );

   modport sink (
      input  valid, pixel_addr, pixel_value, last,
      output ready
   );
endinterface

// File: src/snes_ttr_sheet_ram.sv
// Tile sheet storage: one write port and one read port with registered data.
// Depends on nothing outside this file.
module snes_ttr_sheet_ram #(
   parameter  int unsigned DEPTH  = 65536,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              write_en,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [7:0]        write_data,
   input  logic              read_en,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [7:0]        read_data
);

   logic [7:0] sheet_ff [DEPTH];
   logic [7:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         sheet_ff[write_addr] <= write_data;
      end
   end

   // Read data holds while read_en is low, so it doubles as a stall register.
   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= sheet_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// File: src/snes_ttr_mod_unit.sv
// Shared remainder unit: reduces a 16-bit value modulo one of two constant divisors.
// Reciprocal multiply, back-multiply and one correction; depends on snes_ttr_pkg.
`include "assert_macros.svh"

module snes_ttr_mod_unit import snes_ttr_pkg::*; #(
   parameter int unsigned DIV_SHEET  = 65536,
   parameter int unsigned DIV_SCREEN = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type mod_req,
   output mod_rsp_type mod_rsp
);

   // floor(2^32 / divisor): the quotient estimate is short by at most one.
   localparam logic [31:0] RECIP_SHEET  = 32'((64'd1 << 32) / DIV_SHEET);
   localparam logic [31:0] RECIP_SCREEN = 32'((64'd1 << 32) / DIV_SCREEN);
   localparam logic [16:0] DIVW_SHEET   = 17'(DIV_SHEET);
   localparam logic [16:0] DIVW_SCREEN  = 17'(DIV_SCREEN);

   logic                 v1_ff, v1_in;
   logic                 v2_ff, v2_in;
   div_sel_type          sel_ff, sel_in;
   logic [OPERAND_W-1:0] a_ff, a_in;
   logic [47:0]          prod_ff, prod_in;
   logic [OPERAND_W-1:0] qd_ff, qd_in;

   logic [31:0]          recip_req;
   logic [16:0]          div_cur;
   logic [OPERAND_W-1:0] quot;
   logic [32:0]          qd_full;
   logic [OPERAND_W-1:0] diff;
   logic [16:0]          value_wide;

   always_comb begin
      unique case (mod_req.sel)
         DIV_SEL_SHEET:  recip_req = RECIP_SHEET;
         DIV_SEL_SCREEN: recip_req = RECIP_SCREEN;
         default:        recip_req = RECIP_SHEET;
      endcase
      unique case (sel_ff)
         DIV_SEL_SHEET:  div_cur = DIVW_SHEET;
         DIV_SEL_SCREEN: div_cur = DIVW_SCREEN;
         default:        div_cur = DIVW_SHEET;
      endcase
   end

   always_comb begin
      v1_in   = mod_req.start;
      v2_in   = v1_ff;
      sel_in  = mod_req.start ? mod_req.sel : sel_ff;
      a_in    = mod_req.start ? mod_req.operand : a_ff;
      prod_in = mod_req.start ? 48'(mod_req.operand) * 48'(recip_req) : prod_ff;
      quot    = prod_ff[47:32];
      qd_full = 33'(quot) * 33'(div_cur);
      qd_in   = v1_ff ? qd_full[OPERAND_W-1:0] : qd_ff;
   end

   // Remainder estimate lies below twice the divisor; one subtract fixes it.
   always_comb begin
      diff = a_ff - qd_ff;
      if ({1'b0, diff} >= div_cur) begin
         mod_rsp.value = diff - div_cur[OPERAND_W-1:0];
      end else begin
         mod_rsp.value = diff;
      end
      mod_rsp.done = v2_ff;
   end

   assign value_wide = {1'b0, mod_rsp.value};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff  <= sel_in;
      a_ff    <= a_in;
      prod_ff <= prod_in;
      qd_ff   <= qd_in;
   end

   `ASSERT_CLK(a_rem_below_divisor, mod_rsp.done |-> (value_wide < div_cur), "remainder not below divisor")

endmodule

// File: src/snes_tilemap_tile_renderer.sv
// Top level of the SNES tilemap tile renderer (8x8 tiles, 256-wide bitmap).
// Depends on snes_ttr_pkg, the channel interfaces, snes_ttr_mod_unit and snes_ttr_sheet_ram.
//
//   Channel   Direction  Handshake          Carries
//   req_bus   in         valid/ready        op, sheet_addr, sheet_byte, tile_slot, map_word
//   rsp_bus   out        valid/ready        pixel_addr, pixel_value, last
//   csr       in         csr_write_en       csr_write_data (eight_bpp_mode)
//
// A load beat is accepted and then passes through the shared remainder unit, which folds
// the sheet address into the sheet depth before the write.
// A draw beat is accepted and makes two passes through the remainder unit (slot, then sheet
// base), then reads the sheet once per pixel through the single read port, pausing while a
// result beat stalls. An empty map word is accepted and never leaves the idle state.
// Synchronous active-high reset clears the sequencer, the mode register and the output valid.
// A stalled result beat freezes the pixel loop; the next item is taken while the last pixel waits.
`include "assert_macros.svh"

module snes_tilemap_tile_renderer import snes_ttr_pkg::*; #(
   parameter int unsigned SHEET_DEPTH      = 65536,
   parameter int unsigned TILES_PER_SCREEN = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   snes_ttr_req_if.sink         req_bus,
   snes_ttr_rsp_if.source       rsp_bus,
   input  logic                 csr_write_en,
   input  logic                 csr_write_data
);

   localparam int unsigned    SHEET_AW = $clog2(SHEET_DEPTH);
   localparam logic [SHEET_AW:0] DEPTH_W = (SHEET_AW + 1)'(SHEET_DEPTH);
   localparam logic [SHEET_AW:0] SKIP_W  = (SHEET_AW + 1)'(ROW_SKIP);
   localparam logic [SHEET_AW:0] ONE_W   = (SHEET_AW + 1)'(1);

   // Sequencer and mode.
   state_type state_ff, state_in;
   logic      mode_ff;

   // Item fields kept for the whole draw.
   logic [7:0]          byte_ff, byte_in;
   logic [2:0]          pal_ff, pal_in;
   logic                hflip_ff, hflip_in;
   logic                vflip_ff, vflip_in;
   logic [9:0]          id_ff, id_in;
   logic [9:0]          slot_ff, slot_in;
   logic [SHEET_AW-1:0] rd_addr_ff, rd_addr_in;
   logic [5:0]          cnt_ff, cnt_in;

   // Output stage: sits alongside the registered read data of the sheet.
   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_addr_ff, s1_addr_in;
   logic [2:0]  s1_pal_ff, s1_pal_in;
   logic        s1_last_ff, s1_last_in;

   logic        req_acc;
   logic        draw_adv;
   mod_req_type mod_req;
   mod_rsp_type mod_rsp;
   logic        mem_we;
   logic        mem_re;
   logic [7:0]  mem_rdata;

   logic [OPERAND_W-1:0] base_word;
   logic [SHEET_AW:0]    addr_sum;
   logic [SHEET_AW:0]    rd_addr_wide;
   logic [2:0]           mx;
   logic [2:0]           my;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc       = req_bus.valid && req_bus.ready;

   // The pixel loop moves when the output stage is empty or being drained.
   assign draw_adv = !s1_valid_ff || rsp_bus.ready;

   // Tile id splits into a sheet row of 16 tiles and a column inside it.
   assign base_word = {id_ff[9:4], 3'b000, id_ff[3:0], 3'b000};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_bus.op == OP_LOAD) begin
                  state_in = ST_LOAD_MOD;
               end else if (req_bus.map_word != EMPTY_MAP_WORD) begin
                  state_in = ST_SLOT_MOD;
               end
            end
         end
         ST_LOAD_MOD: begin
            if (mod_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         ST_SLOT_MOD: begin
            if (mod_rsp.done) begin
               state_in = ST_BASE_MOD;
            end
         end
         ST_BASE_MOD: begin
            if (mod_rsp.done) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (draw_adv && cnt_ff == LAST_PIXEL) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: remainder requests, sheet write and sheet read.
   always_comb begin
      mod_req.start   = 1'b0;
      mod_req.sel     = DIV_SEL_SHEET;
      mod_req.operand = '0;
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_bus.op == OP_LOAD) begin
               mod_req.start   = 1'b1;
               mod_req.operand = req_bus.sheet_addr;
            end else if (req_acc && req_bus.map_word != EMPTY_MAP_WORD) begin
               mod_req.start   = 1'b1;
               mod_req.sel     = DIV_SEL_SCREEN;
               mod_req.operand = OPERAND_W'(req_bus.tile_slot);
            end
         end
         ST_LOAD_MOD: begin
            mem_we = mod_rsp.done;
         end
         ST_SLOT_MOD: begin
            // The slot result and the base request share this cycle.
            mod_req.start   = mod_rsp.done;
            mod_req.operand = base_word;
         end
         ST_BASE_MOD: begin
         end
         ST_DRAW: begin
            mem_re = draw_adv;
         end
         default: begin
         end
      endcase
   end

   // Sheet walk: step along the row, jump to the next row after the eighth byte,
   // and wrap at the sheet depth.
   always_comb begin
      if (cnt_ff[2:0] == 3'd7) begin
         addr_sum = {1'b0, rd_addr_ff} + SKIP_W;
      end else begin
         addr_sum = {1'b0, rd_addr_ff} + ONE_W;
      end
      if (addr_sum >= DEPTH_W) begin
         addr_sum = addr_sum - DEPTH_W;
      end
   end

   assign mx = hflip_ff ? ~cnt_ff[2:0] : cnt_ff[2:0];
   assign my = vflip_ff ? ~cnt_ff[5:3] : cnt_ff[5:3];

   // Datapath next values.
   always_comb begin
      byte_in     = byte_ff;
      pal_in      = pal_ff;
      hflip_in    = hflip_ff;
      vflip_in    = vflip_ff;
      id_in       = id_ff;
      slot_in     = slot_ff;
      rd_addr_in  = rd_addr_ff;
      cnt_in      = cnt_ff;
      s1_valid_in = s1_valid_ff;
      s1_addr_in  = s1_addr_ff;
      s1_pal_in   = s1_pal_ff;
      s1_last_in  = s1_last_ff;

      if (req_acc) begin
         byte_in  = req_bus.sheet_byte;
         pal_in   = req_bus.map_word[12:10];
         hflip_in = req_bus.map_word[14];
         vflip_in = req_bus.map_word[15];
         id_in    = req_bus.map_word[9:0];
      end
      if (state_ff == ST_SLOT_MOD && mod_rsp.done) begin
         slot_in = mod_rsp.value[9:0];
      end
      if (state_ff == ST_BASE_MOD && mod_rsp.done) begin
         rd_addr_in = mod_rsp.value[SHEET_AW-1:0];
         cnt_in     = '0;
      end
      if (draw_adv) begin
         s1_valid_in = (state_ff == ST_DRAW);
         if (state_ff == ST_DRAW) begin
            rd_addr_in = addr_sum[SHEET_AW-1:0];
            cnt_in     = cnt_ff + 6'd1;
            // Bitmap address: slot row, pixel row, slot column, pixel column.
            s1_addr_in = {slot_ff[9:5], my, slot_ff[4:0], mx};
            s1_pal_in  = pal_ff;
            s1_last_in = (cnt_ff == LAST_PIXEL);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
         if (csr_write_en) begin
            mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      pal_ff     <= pal_in;
      hflip_ff   <= hflip_in;
      vflip_ff   <= vflip_in;
      id_ff      <= id_in;
      slot_ff    <= slot_in;
      rd_addr_ff <= rd_addr_in;
      cnt_ff     <= cnt_in;
      s1_addr_ff <= s1_addr_in;
      s1_pal_ff  <= s1_pal_in;
      s1_last_ff <= s1_last_in;
   end

   snes_ttr_mod_unit #(
      .DIV_SHEET  (SHEET_DEPTH),
      .DIV_SCREEN (TILES_PER_SCREEN)
   ) u_mod_unit (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   snes_ttr_sheet_ram #(
      .DEPTH (SHEET_DEPTH)
   ) u_sheet_ram (
      .clock      (clock),
      .write_en   (mem_we),
      .write_addr (mod_rsp.value[SHEET_AW-1:0]),
      .write_data (byte_ff),
      .read_en    (mem_re),
      .read_addr  (rd_addr_ff),
      .read_data  (mem_rdata)
   );

   // Outside 8bpp mode the palette selects a group of 16 colors, wrapping at 256.
   assign rsp_bus.valid       = s1_valid_ff;
   assign rsp_bus.pixel_addr  = s1_addr_ff;
   assign rsp_bus.pixel_value = mode_ff ? mem_rdata : mem_rdata + {s1_pal_ff, 4'b0000};
   assign rsp_bus.last        = s1_last_ff;

   assign rd_addr_wide = {1'b0, rd_addr_ff};

   `ASSERT_CLK(a_mod_done_when_waiting, mod_rsp.done |-> (state_ff == ST_LOAD_MOD || state_ff == ST_SLOT_MOD || state_ff == ST_BASE_MOD), "remainder result with no waiting step")
   `ASSERT_NEXT(a_last_closes_draw, state_ff == ST_DRAW && draw_adv && cnt_ff == LAST_PIXEL, s1_valid_ff && s1_last_ff && state_ff == ST_IDLE, "final pixel did not close the draw")
   `ASSERT_CLK(a_read_addr_in_sheet, (state_ff == ST_DRAW) |-> (rd_addr_wide < DEPTH_W), "sheet read address beyond depth")

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for snes_tilemap_tile_renderer: random and directed sheet loads and
// tile draws, with pixel beats checked against a scoreboard. Needs snes_ttr_pkg, both channel
// interfaces and the renderer RTL.
module testbench;
   import snes_ttr_pkg::*;

   // Clock period is 12 ns.
   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 10;
   // Loads produce no pixels, so the drain before a mode write must cover a load that could
   // still be running.
   localparam int DRAIN_CYCLES   = 96;
   // One long receiver hold, so the pixel path backs up and the input channel stalls.
   localparam int SQUEEZE_CYCLES = 700;
   // Consecutive cycles with no beat on either channel before the run is declared hung.
   localparam int STALL_LIMIT    = 5000;
   localparam int PHASE_ITEMS    = 80;
   // Tiles 0 and 1023 plus a few more random tiles get fully loaded and become drawable.
   localparam int MAX_TILES      = 5;

   // One expected pixel beat.
   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  value;
      logic        last;
   } pixel_type;

   // Scoreboard: mirrors the tile sheet and the mode bit, expands each accepted draw of a
   // non-empty map word into its 64 pixel beats and checks the result channel against them in order.
   class pixel_scoreboard;
      logic [7:0] sheet [65536];
      bit         eight_bpp;
      pixel_type  pending [$];
      int         errors;

      function void set_mode(bit mode);
         eight_bpp = mode;
      endfunction

      function void note_item(logic op, logic [15:0] addr, logic [7:0] data,
                              logic [9:0] slot, logic [15:0] word);
         logic [9:0] id;
         logic [2:0] pal;
         logic [2:0] mx;
         logic [2:0] my;
         logic [7:0] px;
         pixel_type  pix;
         if (op == OP_LOAD) begin
            sheet[addr] = data;
            return;
         end
         if (word == EMPTY_MAP_WORD) return;
         id  = word[9:0];
         pal = word[12:10];
         // Sheet bytes are read in row order; the flips only move where each one lands.
         for (int yl = 0; yl < 8; yl++) begin
            for (int xl = 0; xl < 8; xl++) begin
               mx = word[14] ? 3'(7 - xl) : 3'(xl);
               my = word[15] ? 3'(7 - yl) : 3'(yl);
               px = sheet[{id[9:4], 3'(yl), id[3:0], 3'(xl)}];
               if (!eight_bpp) px = px + {pal, 4'b0000};
               pix.addr  = {slot[9:5], my, slot[4:0], mx};
               pix.value = px;
               pix.last  = (yl == 7 && xl == 7);
               pending   = {pending, pix};
            end
         end
      endfunction

      function void check_pixel(logic [15:0] addr, logic [7:0] value, logic last);
         pixel_type want;
         if (pending.size() == 0) begin
            $error("pixel beat with nothing expected: pixel_addr %h", addr);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (addr !== want.addr) begin
            $error("pixel_addr: expected %h, actual %h", want.addr, addr);
            errors++;
         end
         if (value !== want.value) begin
            $error("pixel_value: expected %h, actual %h", want.value, value);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;

   snes_ttr_req_if req_bus ();
   snes_ttr_rsp_if rsp_bus ();

   pixel_scoreboard board;
   logic [9:0]      ready_tiles [$];
   int              burst_left;
   int              idle_cycles;
   bit              squeeze_req;
   bit              squeeze_done;

   snes_tilemap_tile_renderer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // Both channels are sampled at the rising edge, so the handshake values seen here are the
   // ones from before the edge, whatever order the processes run in.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         board.note_item(req_bus.op, req_bus.sheet_addr, req_bus.sheet_byte,
                         req_bus.tile_slot, req_bus.map_word);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_pixel(rsp_bus.pixel_addr, rsp_bus.pixel_value, rsp_bus.last);
      end
   end

   // Watchdog: a run where neither channel moves for too long is hung.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL snes_tilemap_tile_renderer");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: segments of random length, each either fully ready, randomly ready, or ready
   // on a fixed one-in-five pattern. Once asked, it holds off for one long stretch.
   initial begin : receiver
      int span;
      int style;
      int tick;
      rsp_bus.ready = 1'b0;
      tick = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(16, 160);
         if (squeeze_req && !squeeze_done) begin
            squeeze_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end
         repeat (span) begin
            case (style)
               2: begin
                  rsp_bus.ready <= 1'($urandom_range(0, 1));
               end
               3: begin
                  rsp_bus.ready <= (tick % 5 == 0);
               end
               default: begin
                  rsp_bus.ready <= 1'b1;
               end
            endcase
            tick++;
            @(posedge clock);
         end
      end
   end

   // Offers one beat and returns at the edge where it is accepted. Valid is left high so a
   // following beat in the same burst goes out back to back; gaps come between bursts.
   task automatic send_beat(logic op, logic [15:0] addr, logic [7:0] data,
                            logic [9:0] slot, logic [15:0] word);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.sheet_addr <= addr;
      req_bus.sheet_byte <= data;
      req_bus.tile_slot  <= slot;
      req_bus.map_word   <= word;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // The fields that an operation ignores still carry random values.
   task automatic load_byte(logic [15:0] addr, logic [7:0] data);
      send_beat(OP_LOAD, addr, data, 10'($urandom), 16'($urandom));
   endtask

   task automatic draw_tile(logic [9:0] slot, logic [15:0] word);
      send_beat(OP_DRAW, 16'($urandom), 8'($urandom), slot, word);
   endtask

   // Loads every byte of one tile with random content and makes the tile drawable. All 64
   // beats have been accepted when the loop ends, so the tile is complete by then.
   task automatic fill_tile(logic [9:0] id);
      for (int n = 0; n < 64; n++) begin
         load_byte({id[9:4], 3'(n / 8), id[3:0], 3'(n % 8)}, 8'($urandom));
      end
      ready_tiles = {ready_tiles, id};
   endtask

   // Waits until every expected pixel has come back, then lets a possible trailing draw or
   // load finish before anything touches the mode register.
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(bit mode);
      csr_write_en   <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      board.set_mode(mode);
      csr_write_en   <= 1'b0;
   endtask

   // Mostly draws of loaded tiles with random slots and flags, mixed with edits inside loaded
   // tiles, stray loads anywhere in the sheet, empty map words and now and then a new tile.
   // Only fully loaded tiles are ever drawn, so no unwritten sheet byte is read.
   task automatic random_phase(int quota);
      int          sent;
      int          pick;
      logic [9:0]  id;
      logic [15:0] word;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 99);
         id   = ready_tiles[$urandom_range(0, ready_tiles.size() - 1)];
         if (pick < 65 && pick >= 45) begin
            load_byte({id[9:4], 3'($urandom), id[3:0], 3'($urandom)}, 8'($urandom));
            sent++;
         end else if (pick >= 65 && pick < 85) begin
            load_byte(16'($urandom), 8'($urandom));
            sent++;
         end else if (pick >= 85 && pick < 93) begin
            draw_tile(10'($urandom), EMPTY_MAP_WORD);
            sent++;
         end else if (pick >= 93 && ready_tiles.size() < MAX_TILES) begin
            fill_tile(10'($urandom_range(1, 1022)));
            sent += 64;
         end else begin
            word       = 16'($urandom);
            word[9:0]  = id;
            draw_tile(10'($urandom), word);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      board          = new;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_LOAD;
      req_bus.sheet_addr = '0;
      req_bus.sheet_byte = '0;
      req_bus.tile_slot  = '0;
      req_bus.map_word   = '0;
      burst_left     = 0;
      squeeze_req    = 1'b0;
      squeeze_done   = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);

      // The lowest and the highest tile id get loaded first; the directed draws use them.
      fill_tile(10'd0);
      fill_tile(10'd1023);

      // Directed part with palette offset: extreme sheet addresses and bytes, corner slots,
      // each flip on its own and both together, the priority bit, every palette bit and the
      // empty map word. A byte of FF plus palette 7 checks the wrap of the offset.
      load_byte(16'h0000, 8'h00);
      load_byte(16'hFFFF, 8'hFF);
      draw_tile(10'd0,    16'h0000);
      draw_tile(10'd1023, 16'h5FFF);
      draw_tile(10'd31,   16'h8000);
      draw_tile(10'd992,  16'hF7FF);
      draw_tile(10'd5,    EMPTY_MAP_WORD);
      draw_tile(10'd0,    16'h1FFF);
      draw_tile(10'd512,  16'h7FFF);
      draw_tile(10'd33,   16'hBFFF);
      draw_tile(10'd1000, 16'hFC00);
      draw_tile(10'h2AA,  16'h0400);
      settle();

      // Same kind of draws with the palette offset switched off.
      write_mode(1'b1);
      draw_tile(10'd0,    16'h1FFF);
      draw_tile(10'd1023, 16'hDC00);
      draw_tile(10'd77,   EMPTY_MAP_WORD);
      draw_tile(10'd544,  16'h7FFF);
      settle();

      // Random phases alternate the mode; the long receiver hold lands in the first one.
      write_mode(1'b0);
      squeeze_req = 1'b1;
      random_phase(PHASE_ITEMS);
      settle();
      write_mode(1'b1);
      random_phase(PHASE_ITEMS);
      settle();
      write_mode(1'b0);
      random_phase(PHASE_ITEMS);
      settle();
      write_mode(1'b1);
      random_phase(PHASE_ITEMS);
      settle();

      if (board.errors == 0) begin
         $display("PASS snes_tilemap_tile_renderer");
      end else begin
         $display("FAIL snes_tilemap_tile_renderer");
      end
      $finish;
   end
endmodule

// File: filelist.f
+incdir+src
src/snes_ttr_pkg.sv
src/snes_ttr_req_if.sv
src/snes_ttr_rsp_if.sv
src/snes_ttr_sheet_ram.sv
src/snes_ttr_mod_unit.sv
src/snes_tilemap_tile_renderer.sv
verif/testbench.sv
